// ===== hdl/mbrtu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbrtu_pkg;

  // frame store depth, 8 to 256
  localparam int BUFFER_BYTES = 256;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = 9;

  localparam logic [CNT_W-1:0] BUF_LIMIT = CNT_W'(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(4);

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic [7:0] OWN_ADDR_RESET = 8'h01;

  // input item kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_GAP  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // result kinds
  localparam logic RES_VERDICT = 1'b0;
  localparam logic RES_READ    = 1'b1;

  // verdict status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_CRC   = 2'd2;
  localparam logic [1:0] STATUS_ADDR  = 2'd3;

  typedef enum logic [3:0] {
    RX_INIT  = 4'b0001,
    RX_IDLE  = 4'b0010,
    RX_RCV   = 4'b0100,
    RX_ERROR = 4'b1000
  } rx_state_t;

  typedef struct packed {
    logic             result_kind;
    logic [1:0]       status;
    logic [CNT_W-1:0] frame_length;
    logic [7:0]       function_code;
    logic             broadcast;
    logic [7:0]       read_data;
  } result_t;

  // one byte through the reflected Modbus CRC-16
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mbrtu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mbrtu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, kind, rx_byte, read_index, input ready);
  modport sink (input valid, kind, rx_byte, read_index, output ready);
endinterface

interface mbrtu_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [1:0] status;
  logic [8:0] frame_length;
  logic [7:0] function_code;
  logic       broadcast;
  logic [7:0] read_data;

  modport source (output valid, result_kind, status, frame_length, function_code, broadcast,
                  read_data, input ready);
  modport sink (input valid, result_kind, status, frame_length, function_code, broadcast,
                read_data, output ready);
endinterface

`default_nettype wire

// ===== hdl/modbus_rtu_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Modbus RTU receive framer. Each input transfer is a received byte, a gap-timer
// expiry or a frame store read; one transfer is taken every clock cycle unless the
// output stalls. Bytes are ignored after reset until the first gap. A gap that
// closes a frame yields a verdict (ok, too short, CRC bad, address mismatch) with
// length, function code and broadcast flag; a read yields the stored byte. Results
// pass through the stage register (state update, registered frame store read) and
// then the output register; together they let a new item in while a result waits
// to be taken. own_address is loaded via cfg_we.
module modbus_rtu_frame_receiver_unit
  import mbrtu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  mbrtu_in_if.sink        in_chan,
  mbrtu_out_if.source     out_chan
);

  logic [7:0] mem [BUFFER_BYTES];

  rx_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       own_addr_r;

  logic              s1_valid_r, s1_valid_nxt;
  result_t           s1_res_r, s1_res_nxt;
  logic              s1_rd_sel_r, s1_rd_sel_nxt;
  logic [7:0]        mem_q_r;

  logic    out_valid_r;
  result_t out_res_r;

  logic              accept;
  logic              s1_adv;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [1:0]        verdict;
  result_t           s1_out;

  assign s1_adv         = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = !s1_valid_r || s1_adv;
  assign accept         = in_chan.valid && in_chan.ready;
  assign rd_en          = accept && (in_chan.kind == KIND_READ);

  always_comb begin
    if (count_r < MIN_FRAME) begin
      verdict = STATUS_SHORT;
    end else if (crc_r != 16'h0000) begin
      verdict = STATUS_CRC;
    end else if (addr_r != own_addr_r && addr_r != 8'h00) begin
      verdict = STATUS_ADDR;
    end else begin
      verdict = STATUS_OK;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    crc_nxt       = crc_r;
    addr_nxt      = addr_r;
    func_nxt      = func_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[ADDR_W-1:0];
    s1_valid_nxt  = 1'b0;
    s1_res_nxt    = '0;
    s1_rd_sel_nxt = 1'b0;

    if (accept) begin
      case (in_chan.kind)
        KIND_BYTE: begin
          unique case (state_r)
            RX_IDLE: begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              addr_nxt  = in_chan.rx_byte;
              func_nxt  = 8'h00;
              count_nxt = CNT_W'(1);
              crc_nxt   = crc_fold(CRC_START, in_chan.rx_byte);
              state_nxt = RX_RCV;
            end
            RX_RCV: begin
              if (count_r < BUF_LIMIT) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                crc_nxt   = crc_fold(crc_r, in_chan.rx_byte);
                if (count_r == CNT_W'(1)) begin
                  func_nxt = in_chan.rx_byte;
                end
              end else begin
                // overflow: frame gets dropped at the next gap
                state_nxt = RX_ERROR;
              end
            end
            RX_INIT, RX_ERROR: begin
            end
            default: begin
            end
          endcase
        end
        KIND_GAP: begin
          if (state_r == RX_RCV) begin
            s1_valid_nxt             = 1'b1;
            s1_res_nxt.result_kind   = RES_VERDICT;
            s1_res_nxt.status        = verdict;
            s1_res_nxt.frame_length  = count_r;
            s1_res_nxt.function_code = func_r;
            s1_res_nxt.broadcast     = (addr_r == 8'h00);
          end
          state_nxt = RX_IDLE;
        end
        KIND_READ: begin
          s1_valid_nxt           = 1'b1;
          s1_res_nxt.result_kind = RES_READ;
          s1_rd_sel_nxt          = ({1'b0, in_chan.read_index} < BUF_LIMIT);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_chan.rx_byte;
    end
    if (rd_en) begin
      mem_q_r <= mem[in_chan.read_index[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= RX_INIT;
      count_r    <= '0;
      crc_r      <= CRC_START;
      addr_r     <= 8'h00;
      func_r     <= 8'h00;
      own_addr_r <= OWN_ADDR_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      addr_r  <= addr_nxt;
      func_r  <= func_nxt;
      if (cfg_we) begin
        own_addr_r <= cfg_wdata;
      end
    end
  end

  // stage register: loaded on every input transfer, held while the output stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r    <= s1_res_nxt;
      s1_rd_sel_r <= s1_rd_sel_nxt;
    end
  end

  always_comb begin
    s1_out           = s1_res_r;
    s1_out.read_data = s1_rd_sel_r ? mem_q_r : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_res_r <= s1_out;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_kind   = out_res_r.result_kind;
  assign out_chan.status        = out_res_r.status;
  assign out_chan.frame_length  = out_res_r.frame_length;
  assign out_chan.function_code = out_res_r.function_code;
  assign out_chan.broadcast     = out_res_r.broadcast;
  assign out_chan.read_data     = out_res_r.read_data;

endmodule

`default_nettype wire

// ===== tb/modbus_rtu_frame_receiver_unit_tb.sv =====
`timescale 1ns / 1ps

module modbus_rtu_frame_receiver_unit_tb;
  import mbrtu_pkg::*;

  localparam int PHASE_ITEMS  = 100;
  localparam int SETTLE_TICKS = 6;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } rx_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  mbrtu_in_if  in_if ();
  mbrtu_out_if out_if ();

  modbus_rtu_frame_receiver_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_BYTE;
    in_if.rx_byte    = 8'h00;
    in_if.read_index = 8'h00;
    out_if.ready     = 1'b0;
  end

  // stimulus bookkeeping
  rx_item_t   tx_queue[$];
  rx_item_t   head_item;
  int         items_sent = 0;
  int         items_taken = 0;
  int         counted = 0;
  bit         steady = 1'b0;
  rx_state_t  plan_state = RX_INIT;
  int         plan_len = 0;
  int         filled = 0;

  // receiver mirror
  rx_state_t   rx_state = RX_INIT;
  logic [8:0]  frame_len = '0;
  logic [15:0] crc_acc = CRC_START;
  logic [7:0]  addr_seen = 8'h00;
  logic [7:0]  func_seen = 8'h00;
  logic [7:0]  own_addr = OWN_ADDR_RESET;
  logic [7:0]  frame_copy [BUFFER_BYTES];
  result_t     results_due[$];

  int mismatches = 0;
  int verdict_tally [4] = '{0, 0, 0, 0};
  int reads_seen = 0;
  int settings_used = 0;

  function automatic bit stall_now();
    return !steady && ($urandom_range(99) < 29);
  endfunction

  // bit-serial form of the reflected Modbus CRC
  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ data[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void track_frame(input logic [1:0] kind, input logic [7:0] rxb,
                                      input logic [7:0] idx);
    result_t r;
    r = '0;
    case (kind)
      KIND_BYTE: begin
        if (rx_state == RX_IDLE) begin
          frame_len     = 9'd1;
          crc_acc       = crc16_next(CRC_START, rxb);
          addr_seen     = rxb;
          func_seen     = 8'h00;
          frame_copy[0] = rxb;
          rx_state      = RX_RCV;
        end else if (rx_state == RX_RCV) begin
          if (frame_len < BUF_LIMIT) begin
            frame_copy[frame_len[7:0]] = rxb;
            if (frame_len == 9'd1) func_seen = rxb;
            crc_acc   = crc16_next(crc_acc, rxb);
            frame_len = frame_len + 9'd1;
          end else begin
            rx_state = RX_ERROR;
          end
        end
      end
      KIND_GAP: begin
        if (rx_state == RX_RCV) begin
          r.result_kind = RES_VERDICT;
          if (frame_len < MIN_FRAME) r.status = STATUS_SHORT;
          else if (crc_acc != 16'h0000) r.status = STATUS_CRC;
          else if (addr_seen != own_addr && addr_seen != 8'h00) r.status = STATUS_ADDR;
          else r.status = STATUS_OK;
          r.frame_length  = frame_len;
          r.function_code = func_seen;
          r.broadcast     = (addr_seen == 8'h00);
          results_due.push_back(r);
        end
        rx_state = RX_IDLE;
      end
      KIND_READ: begin
        r.result_kind = RES_READ;
        r.read_data   = (int'(idx) < BUFFER_BYTES) ? frame_copy[idx] : 8'h00;
        results_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // unused fields carry random bits so every input bit toggles
  function automatic void send(input logic [1:0] kind, input logic [7:0] b,
                               input logic [7:0] idx);
    rx_item_t it;
    it.kind       = kind;
    it.rx_byte    = b;
    it.read_index = idx;
    tx_queue.push_back(it);
    items_sent++;
    if (kind != KIND_NONE) counted++;
    if (kind == KIND_BYTE) begin
      if (plan_state == RX_IDLE) begin
        plan_len   = 1;
        plan_state = RX_RCV;
      end else if (plan_state == RX_RCV) begin
        if (plan_len < BUFFER_BYTES) plan_len++;
        else plan_state = RX_ERROR;
      end
      if (plan_state == RX_RCV && plan_len > filled) filled = plan_len;
    end else if (kind == KIND_GAP) begin
      plan_state = RX_IDLE;
    end
  endfunction

  function automatic void send_byte(input logic [7:0] b);
    send(KIND_BYTE, b, 8'($urandom_range(255)));
  endfunction

  function automatic void send_gap();
    send(KIND_GAP, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endfunction

  // only positions already written since reset are read
  function automatic void send_read();
    if (filled > 0) send(KIND_READ, 8'($urandom_range(255)), 8'($urandom_range(filled - 1)));
  endfunction

  function automatic void send_frame(input logic [7:0] addr, input logic [7:0] fc,
                                     input int body, input bit bad_crc, input bit mixed);
    logic [15:0] c;
    logic [7:0]  b;
    c = crc16_next(CRC_START, addr);
    send_byte(addr);
    for (int i = 0; i < body; i++) begin
      b = (i == 0) ? fc : 8'($urandom_range(255));
      c = crc16_next(c, b);
      send_byte(b);
      if (mixed && $urandom_range(99) < 8) begin
        if ($urandom_range(1)) send_read();
        else send(KIND_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(15));
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    send_gap();
  endfunction

  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(99);
    if (r < 50) return own_addr;
    if (r < 70) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic void random_phase(input bit big_frames);
    int start;
    int r;
    start = counted;
    if (big_frames) begin
      // largest legal frame, then one that overruns the buffer and is dropped
      send_frame(own_addr, 8'h10, BUFFER_BYTES - 3, 1'b0, 1'b0);
      send(KIND_READ, 8'h00, 8'hFF);
      for (int i = 0; i < BUFFER_BYTES + 4; i++) send_byte(8'($urandom_range(255)));
      send_gap();
      send(KIND_READ, 8'hFF, 8'hFF);
      send(KIND_READ, 8'h00, 8'h80);
    end
    while (counted - start < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 62) begin
        send_frame(pick_addr(), 8'($urandom_range(255)), $urandom_range(1, 10),
                   $urandom_range(99) < 12, 1'b1);
      end else if (r < 70) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        send_gap();
      end else if (r < 82) begin
        send_read();
      end else if (r < 88) begin
        send_gap();
      end else if (r < 92) begin
        send(KIND_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (r < 96) begin
        // truncated frame, the gap arrives early
        send_byte(pick_addr());
        repeat ($urandom_range(3, 6)) send_byte(8'($urandom_range(255)));
        send_gap();
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic write_own(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    own_addr = v;
    settings_used++;
  endtask

  // bytes leave no result, so allow the pipeline to settle afterwards
  task automatic wait_drained();
    while (items_taken != items_sent || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (tx_queue.size() > 0 && !stall_now()) begin
        head_item = tx_queue.pop_front();
        in_if.valid      <= 1'b1;
        in_if.kind       <= head_item.kind;
        in_if.rx_byte    <= head_item.rx_byte;
        in_if.read_index <= head_item.read_index;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        items_taken++;
        track_frame(in_if.kind, in_if.rx_byte, in_if.read_index);
      end
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          $error("result transfer with nothing expected (kind %0d)", out_if.result_kind);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("result_kind", want.result_kind, out_if.result_kind);
          check_field("status", want.status, out_if.status);
          check_field("frame_length", want.frame_length, out_if.frame_length);
          check_field("function_code", want.function_code, out_if.function_code);
          check_field("broadcast", want.broadcast, out_if.broadcast);
          check_field("read_data", want.read_data, out_if.read_data);
          if (want.result_kind == RES_READ) reads_seen++;
          else verdict_tally[want.status]++;
        end
      end
      out_if.ready <= !stall_now();
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_own(8'd1);

    // directed: ignored bytes before the first gap, idle gaps, short frames,
    // minimal good frame, read back, broadcast
    send_byte(8'h00);
    send_byte(8'hFF);
    send(KIND_NONE, 8'hFF, 8'hFF);
    send_gap();
    send_gap();
    send_byte(8'h00);
    send_gap();
    send_byte(own_addr);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_gap();
    send_frame(own_addr, 8'h03, 1, 1'b0, 1'b0);
    send(KIND_READ, 8'h00, 8'h00);
    send(KIND_READ, 8'hFF, 8'h03);
    send_frame(8'h00, 8'h06, 1, 1'b0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_own(8'd247);
        1: write_own(8'd1);
        default: write_own(8'($urandom_range(1, 247)));
      endcase
      steady = (ph == 3);
      random_phase(ph == 2);
      wait_drained();
    end
    steady = 1'b0;

    $display("covered %0d input transfers over %0d address settings", items_taken,
             settings_used);
    $display("verdicts ok/short/crc/addr: %0d/%0d/%0d/%0d, buffer reads: %0d",
             verdict_tally[STATUS_OK], verdict_tally[STATUS_SHORT], verdict_tally[STATUS_CRC],
             verdict_tally[STATUS_ADDR], reads_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mbrtu_pkg.sv
hdl/mbrtu_if.sv
hdl/modbus_rtu_frame_receiver_unit.sv
tb/modbus_rtu_frame_receiver_unit_tb.sv
